/* rtl/wam_pkg.sv */
// ----------------------------------------------------------------------------
// wam_pkg
// Shared widths, event and phase codes and the result type of the wake-up
// address matcher.
// ----------------------------------------------------------------------------
package wam_pkg;

  localparam int unsigned AddrWidthDefault = 32;
  localparam int unsigned TargetWidth      = 32;
  localparam int unsigned BitsWidth        = 6;

  // event codes
  localparam logic [1:0] EvWakeStart = 2'd0;
  localparam logic [1:0] EvSync      = 2'd1;
  localparam logic [1:0] EvTick      = 2'd2;
  localparam logic [1:0] EvDischDone = 2'd3;

  // phase codes
  localparam logic [1:0] PhIdle      = 2'd0;
  localparam logic [1:0] PhSync      = 2'd1;
  localparam logic [1:0] PhSample    = 2'd2;
  localparam logic [1:0] PhDischarge = 2'd3;

  // configuration register indexes
  localparam logic CfgTarget   = 1'b0;
  localparam logic CfgAddrBits = 1'b1;

  typedef struct packed {
    logic                 wake_confirm;
    logic                 discharge_on;
    logic                 sampling_busy;
    logic [1:0]           phase_now;
    logic [BitsWidth-1:0] bits_remaining;
  } result_t;

endpackage

/* rtl/wakeup_address_matcher_unit.sv */
// ----------------------------------------------------------------------------
// wakeup_address_matcher_unit
// Address decoder of a wake-up receiver, one event per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one event: kind_i and
//   data_bit_i. Output channel (out_valid_o / out_stall_i) carries one result
//   per event showing the state after that event. The config channel
//   (cfg_valid_i / cfg_ready_o, always ready) writes target_address (index 0)
//   or address_bits (index 1); write only while the block is idle.
//   Throughput: one item per cycle while in_stall_o is low; the state update
//   and address compare are done in the accepting cycle, the result goes to
//   an output register.
//   A skid register behind the output register lets one more item in while
//   the receiver stalls; in_stall_o rises only when that skid is full, so
//   in_stall_o is a register and does not depend on out_stall_i in the
//   same cycle.
//   Reset: phase idle, bit count, shift register, busy flag and both config
//   registers cleared, no result pending.
// ----------------------------------------------------------------------------
module wakeup_address_matcher_unit
  import wam_pkg::*;
#(
  parameter int unsigned AddressWidth = AddrWidthDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic                   cfg_index_i,
  input  logic [TargetWidth-1:0] cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             kind_i,
  input  logic                   data_bit_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   wake_confirm_o,
  output logic                   discharge_on_o,
  output logic                   sampling_busy_o,
  output logic [1:0]             phase_now_o,
  output logic [BitsWidth-1:0]   bits_remaining_o
);

  typedef enum logic [1:0] {
    StIdle      = PhIdle,
    StSync      = PhSync,
    StSample    = PhSample,
    StDischarge = PhDischarge
  } state_e;

  localparam logic [BitsWidth:0] SatBits = (BitsWidth+1)'(AddressWidth);

  state_e                  state_q, state_d;
  logic [BitsWidth-1:0]    count_q, count_d;
  logic [AddressWidth-1:0] shift_q, shift_d, shift_in;
  logic                    busy_q, busy_d;
  logic [TargetWidth-1:0]  target_q;
  logic [BitsWidth-1:0]    addr_bits_q;
  logic [AddressWidth-1:0] target_cmp;
  logic [BitsWidth:0]      addr_bits_ext;
  logic [BitsWidth-1:0]    load_count;
  logic                    confirm;
  logic                    in_accept;
  logic                    out_free;
  result_t                 res_d, out_q, skid_q;
  logic                    out_valid_q, skid_valid_q;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = skid_valid_q;
  assign in_accept   = in_valid_i && !skid_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign target_cmp    = AddressWidth'(target_q);
  assign addr_bits_ext = {1'b0, addr_bits_q};
  assign load_count    = (addr_bits_ext > SatBits) ? BitsWidth'(SatBits) : addr_bits_q;
  assign shift_in      = AddressWidth'({shift_q, data_bit_i});

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    shift_d = shift_q;
    busy_d  = busy_q;
    confirm = 1'b0;
    case (kind_i)
      EvWakeStart: begin
        if (state_q == StIdle) begin
          if (addr_bits_q != '0) begin
            state_d = StSync;
            busy_d  = 1'b1;
          end else begin
            confirm = 1'b1;
            state_d = StDischarge;
          end
        end
      end
      EvSync: begin
        if (state_q == StSync) begin
          count_d = load_count;
          if (load_count == '0) begin
            confirm = 1'b1;
            shift_d = '0;
            state_d = StDischarge;
          end else begin
            state_d = StSample;
          end
        end
      end
      EvTick: begin
        if (state_q == StSample) begin
          count_d = count_q - BitsWidth'(1);
          shift_d = shift_in;
          if (count_d == '0) begin
            confirm = (shift_in == target_cmp);
            shift_d = '0;
            state_d = StDischarge;
          end
        end
      end
      default: begin
        if (state_q == StDischarge) begin
          state_d = StIdle;
          busy_d  = 1'b0;
        end
      end
    endcase
    res_d.wake_confirm   = confirm;
    res_d.discharge_on   = (state_d == StDischarge);
    res_d.sampling_busy  = busy_d;
    res_d.phase_now      = state_d;
    res_d.bits_remaining = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      shift_q     <= '0;
      busy_q      <= 1'b0;
      target_q    <= '0;
      addr_bits_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CfgTarget:   target_q    <= cfg_data_i;
          CfgAddrBits: addr_bits_q <= cfg_data_i[BitsWidth-1:0];
          default:     target_q    <= target_q;
        endcase
      end
      if (in_accept) begin
        state_q <= state_d;
        count_q <= count_d;
        shift_q <= shift_d;
        busy_q  <= busy_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (out_free) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end
      end else if (in_accept) begin
        if (out_free) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (out_free) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_free) begin
        out_q <= skid_q;
      end
    end else if (in_accept) begin
      if (out_free) begin
        out_q <= res_d;
      end else begin
        skid_q <= res_d;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign wake_confirm_o   = out_q.wake_confirm;
  assign discharge_on_o   = out_q.discharge_on;
  assign sampling_busy_o  = out_q.sampling_busy;
  assign phase_now_o      = out_q.phase_now;
  assign bits_remaining_o = out_q.bits_remaining;

endmodule

/* rtl/wam_checker.sv */
// ----------------------------------------------------------------------------
// wam_checker
// Port-level checks of the wake-up address matcher, bound to the top level.
// ----------------------------------------------------------------------------
module wam_checker
  import wam_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic                 wake_confirm_o,
  input logic                 discharge_on_o,
  input logic                 sampling_busy_o,
  input logic [1:0]           phase_now_o,
  input logic [BitsWidth-1:0] bits_remaining_o
);

  // a confirm always starts the discharge
  a_confirm_discharge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && wake_confirm_o |-> discharge_on_o && (phase_now_o == PhDischarge))
    else $error("confirm without discharge");

  a_discharge_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (discharge_on_o == (phase_now_o == PhDischarge)))
    else $error("discharge flag disagrees with phase");

  // sync and sampling always have the busy flag set, sampling also has bits left
  a_sampling_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (phase_now_o == PhSample || phase_now_o == PhSync)
      |-> sampling_busy_o && (phase_now_o == PhSync || bits_remaining_o != '0))
    else $error("sampling phase without busy or bits");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(phase_now_o)
      && $stable(bits_remaining_o) && $stable(wake_confirm_o))
    else $error("stalled item changed");

endmodule

bind wakeup_address_matcher_unit wam_checker u_wam_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .wake_confirm_o   (wake_confirm_o),
  .discharge_on_o   (discharge_on_o),
  .sampling_busy_o  (sampling_busy_o),
  .phase_now_o      (phase_now_o),
  .bits_remaining_o (bits_remaining_o)
);

/* dv/wakeup_address_matcher_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wakeup_address_matcher_unit_tb
// Self-checking bench for the wake-up address matcher. A behavioral copy of
// the decoder predicts the status item of every accepted event; a monitor
// compares each status item leaving the block, field by field, in order.
// Directed tests cover zero address mode, events out of phase, match and
// mismatch, a zero length at sync and an overlong length. A random part
// then runs mostly well-formed frames under changing settings, with random
// gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module wakeup_address_matcher_unit_tb;
  import wam_pkg::*;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic                   cfg_index_i;
  logic [TargetWidth-1:0] cfg_data_i;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic [1:0]             kind_i;
  logic                   data_bit_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic                   wake_confirm_o;
  logic                   discharge_on_o;
  logic                   sampling_busy_o;
  logic [1:0]             phase_now_o;
  logic [BitsWidth-1:0]   bits_remaining_o;

  wakeup_address_matcher_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .kind_i           (kind_i),
    .data_bit_i       (data_bit_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .wake_confirm_o   (wake_confirm_o),
    .discharge_on_o   (discharge_on_o),
    .sampling_busy_o  (sampling_busy_o),
    .phase_now_o      (phase_now_o),
    .bits_remaining_o (bits_remaining_o)
  );

  // decoder copy
  logic [1:0]                  phase_q;
  logic [BitsWidth-1:0]        count_q;
  logic [AddrWidthDefault-1:0] shreg_q;
  logic                        busy_q;
  logic [TargetWidth-1:0]      target_cfg;
  logic [BitsWidth-1:0]        length_cfg;

  result_t     status_due[$];
  result_t     status_want;
  int unsigned live_events;
  int unsigned mismatches;
  bit          gaps_on;
  bit          stalls_on;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic result_t advance_matcher(input logic [1:0] kind, input logic bit_val);
    result_t r;
    logic    confirm;
    confirm = 1'b0;
    case (kind)
      EvWakeStart: begin
        if (phase_q == PhIdle) begin
          live_events++;
          if (length_cfg != 0) begin
            phase_q = PhSync;
            busy_q  = 1'b1;
          end else begin
            confirm = 1'b1;
            phase_q = PhDischarge;
          end
        end
      end
      EvSync: begin
        if (phase_q == PhSync) begin
          live_events++;
          count_q = (length_cfg > AddrWidthDefault) ? BitsWidth'(AddrWidthDefault) : length_cfg;
          if (count_q == 0) begin
            confirm = 1'b1;
            shreg_q = '0;
            phase_q = PhDischarge;
          end else begin
            phase_q = PhSample;
          end
        end
      end
      EvTick: begin
        if (phase_q == PhSample) begin
          live_events++;
          count_q = count_q - BitsWidth'(1);
          shreg_q = {shreg_q[AddrWidthDefault-2:0], bit_val};
          if (count_q == 0) begin
            if (shreg_q == target_cfg[AddrWidthDefault-1:0]) confirm = 1'b1;
            shreg_q = '0;
            phase_q = PhDischarge;
          end
        end
      end
      default: begin
        if (phase_q == PhDischarge) begin
          live_events++;
          phase_q = PhIdle;
          busy_q  = 1'b0;
        end
      end
    endcase
    r.wake_confirm   = confirm;
    r.discharge_on   = (phase_q == PhDischarge);
    r.sampling_busy  = busy_q;
    r.phase_now      = phase_q;
    r.bits_remaining = count_q;
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (status_due.size() == 0) begin
        mismatches++;
        $display("%0t: status item expected none actual phase %0d", $time, phase_now_o);
      end else begin
        status_want = status_due.pop_front();
        check_field("wake_confirm", 32'(status_want.wake_confirm), 32'(wake_confirm_o));
        check_field("discharge_on", 32'(status_want.discharge_on), 32'(discharge_on_o));
        check_field("sampling_busy", 32'(status_want.sampling_busy), 32'(sampling_busy_o));
        check_field("phase_now", 32'(status_want.phase_now), 32'(phase_now_o));
        check_field("bits_remaining", 32'(status_want.bits_remaining),
                    32'(bits_remaining_o));
      end
    end
  end

  // receiver stalls
  initial begin : stall_gen
    int n;
    out_stall_i = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      n = stalls_on ? $urandom_range(0, 10) : 0;
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  task automatic send_event(input logic [1:0] kind, input logic bit_val);
    int gap;
    gap = gaps_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    data_bit_i <= bit_val;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    status_due.push_back(advance_matcher(kind, bit_val));
  endtask

  // sender holds off until every status item is back
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (status_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [TargetWidth-1:0] addr, input logic [BitsWidth-1:0] len);
    logic [31:0] junk;
    junk        = $urandom();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CfgTarget;
    cfg_data_i  <= addr;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_index_i <= CfgAddrBits;
    cfg_data_i  <= {junk[31:BitsWidth], len};
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    target_cfg = addr;
    length_cfg = len;
  endtask

  // drives the event that fits the current phase, now and then a random one, until back in idle
  task automatic send_frame(input bit honest);
    logic [1:0] k;
    logic       d;
    do begin
      d = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 15) == 0) begin
        k = 2'($urandom_range(0, 3));
      end else begin
        case (phase_q)
          PhIdle:   k = EvWakeStart;
          PhSync:   k = EvSync;
          PhSample: k = EvTick;
          default:  k = EvDischDone;
        endcase
      end
      if (k == EvTick && phase_q == PhSample && honest) begin
        d = target_cfg[5'(count_q - BitsWidth'(1))] ^ ($urandom_range(0, 39) == 0);
      end
      send_event(k, d);
    end while (phase_q != PhIdle);
  endtask

  task automatic test_zero_address();
    settle();
    write_regs(32'hFFFF_FFFF, 6'd0);
    send_event(EvWakeStart, 1'b1);
    send_event(EvWakeStart, 1'b0);
    send_event(EvSync, 1'b1);
    send_event(EvTick, 1'b1);
    send_event(EvDischDone, 1'b0);
  endtask

  task automatic test_out_of_phase();
    send_event(EvSync, 1'b0);
    send_event(EvTick, 1'b1);
    send_event(EvDischDone, 1'b1);
    settle();
    write_regs(32'h0000_0001, 6'd1);
    send_event(EvWakeStart, 1'b0);
    send_event(EvWakeStart, 1'b1);
    send_event(EvTick, 1'b1);
    send_event(EvDischDone, 1'b0);
    send_event(EvSync, 1'b0);
    send_event(EvWakeStart, 1'b0);
    send_event(EvSync, 1'b1);
    send_event(EvDischDone, 1'b1);
    send_event(EvTick, 1'b1);
    send_event(EvDischDone, 1'b0);
  endtask

  task automatic test_mismatch();
    settle();
    write_regs(32'h0000_0002, 6'd2);
    send_event(EvWakeStart, 1'b0);
    send_event(EvSync, 1'b0);
    send_event(EvTick, 1'b1);
    send_event(EvTick, 1'b1);
    send_event(EvDischDone, 1'b1);
  endtask

  task automatic test_zero_length_at_sync();
    settle();
    write_regs(32'h0000_0005, 6'd3);
    send_event(EvWakeStart, 1'b1);
    settle();
    write_regs(32'h0000_0005, 6'd0);
    send_event(EvSync, 1'b0);
    send_event(EvDischDone, 1'b0);
  endtask

  task automatic test_overlong_length();
    settle();
    write_regs(32'hFFFF_FFFF, 6'd63);
    send_event(EvWakeStart, 1'b0);
    send_event(EvSync, 1'b1);
    send_frame(1'b1);
  endtask

  task automatic test_random();
    int unsigned      stop_at;
    logic [5:0]       len;
    logic [31:0]      addr;
    stop_at = live_events + 560;
    while (live_events < stop_at) begin
      case ($urandom_range(0, 9))
        0:       len = 6'd0;
        1:       len = 6'd1;
        2:       len = 6'd32;
        3:       len = 6'($urandom_range(33, 63));
        4, 5:    len = 6'($urandom_range(0, 63));
        default: len = 6'($urandom_range(2, 8));
      endcase
      addr = $urandom();
      case ($urandom_range(0, 3))
        0:       addr = '0;
        1:       addr = '1;
        default: if (len < 32) addr = addr & ((32'd1 << len) - 32'd1);
      endcase
      settle();
      write_regs(addr, len);
      gaps_on   = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(2, 8)) send_frame($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 7) == 0) begin
        // length changes while waiting for sync
        send_event(EvWakeStart, 1'($urandom_range(0, 1)));
        settle();
        write_regs(addr, 6'($urandom_range(0, 40)));
        send_frame(1'b1);
      end
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CfgTarget;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    kind_i      = EvWakeStart;
    data_bit_i  = 1'b0;
    phase_q     = PhIdle;
    count_q     = '0;
    shreg_q     = '0;
    busy_q      = 1'b0;
    target_cfg  = '0;
    length_cfg  = '0;
    live_events = 0;
    mismatches  = 0;
    gaps_on     = 1'b1;
    stalls_on   = 1'b1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_zero_address();
    test_out_of_phase();
    test_mismatch();
    test_zero_length_at_sync();
    test_overlong_length();
    test_random();

    settle();
    repeat (8) @(posedge clk_i);
    if (status_due.size() != 0) begin
      mismatches++;
      $display("%0t: status items expected 0 actual %0d left", $time, status_due.size());
    end
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
